### rtl/core/quasigroup_block_mix_macros.svh
// Assertion macros for the quasigroup block mix RTL.
// Used by quasigroup_block_mix.sv; expects clk and rst_n in scope.
`ifndef QUASIGROUP_BLOCK_MIX_MACROS_SVH
`define QUASIGROUP_BLOCK_MIX_MACROS_SVH

// Implication checked on every rising edge, muted while reset is held.
`define QBM_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, muted while reset is held.
`define QBM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/core/qbm_pkg.sv
// Shared types, constants and digit functions for the quasigroup block mix.
// No dependencies; imported by every module in rtl/core.
`timescale 1ns / 1ps
`default_nettype none

package qbm_pkg;

  localparam int ROUNDS = 20;
  localparam int DIGITS = 21;
  localparam int WORD_W = 3 * DIGITS;

  typedef logic [WORD_W-1:0] word_t;

  // Data carried from cell to cell: rotating operands and the two chains.
  typedef struct packed {
    word_t a;
    word_t b;
    word_t u;
    word_t v;
  } lane_t;

  // 8x8 quasigroup, indexed by {x, y}.
  localparam logic [2:0] QG_TBL [64] = '{
    3'd2, 3'd0, 3'd4, 3'd3, 3'd5, 3'd7, 3'd1, 3'd6,
    3'd1, 3'd5, 3'd3, 3'd4, 3'd0, 3'd6, 3'd2, 3'd7,
    3'd7, 3'd4, 3'd0, 3'd5, 3'd3, 3'd2, 3'd6, 3'd1,
    3'd0, 3'd2, 3'd7, 3'd6, 3'd1, 3'd4, 3'd5, 3'd3,
    3'd3, 3'd6, 3'd1, 3'd2, 3'd7, 3'd5, 3'd4, 3'd0,
    3'd6, 3'd3, 3'd5, 3'd0, 3'd4, 3'd1, 3'd7, 3'd2,
    3'd4, 3'd7, 3'd2, 3'd1, 3'd6, 3'd0, 3'd3, 3'd5,
    3'd5, 3'd1, 3'd6, 3'd7, 3'd2, 3'd3, 3'd0, 3'd4
  };

  // Digit-wise quasigroup operation; digits are independent lookups.
  function automatic word_t qop(input word_t p, input word_t q);
    word_t r;
    r = '0;
    for (int d = 0; d < DIGITS; d++) begin
      r[3*d +: 3] = QG_TBL[{p[3*d +: 3], q[3*d +: 3]}];
    end
    return r;
  endfunction

  // Rotate right by one digit within the word.
  function automatic word_t rot_digit(input word_t w);
    return {w[2:0], w[WORD_W-1:3]};
  endfunction

endpackage

`default_nettype wire

### rtl/core/qbm_round_cell.sv
// One mixing round: rotates both operands and advances both chains.
// Depends on qbm_pkg.
`timescale 1ns / 1ps
`default_nettype none

module qbm_round_cell (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           en,
  input  wire logic           in_vld,
  input  wire qbm_pkg::lane_t in_lane,
  output logic                out_vld,
  output qbm_pkg::lane_t      out_lane
);
  import qbm_pkg::*;

  logic  vld_r, vld_nxt;
  lane_t lane_r, lane_nxt;
  word_t a_rot, b_rot;

  // Round function
  always_comb begin
    a_rot       = rot_digit(in_lane.a);
    b_rot       = rot_digit(in_lane.b);
    lane_nxt.a  = a_rot;
    lane_nxt.b  = b_rot;
    lane_nxt.u  = qop(in_lane.u, a_rot);
    lane_nxt.v  = qop(in_lane.v, b_rot);
    vld_nxt     = in_vld;
  end

  // Valid flag, cleared by reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= vld_nxt;
    end
  end

  // Payload, no reset
  always_ff @(posedge clk) begin
    if (en) begin
      lane_r <= lane_nxt;
    end
  end

  assign out_vld  = vld_r;
  assign out_lane = lane_r;

endmodule

`default_nettype wire

### rtl/core/qbm_final_cell.sv
// Output cell: folds the two chains into the result and holds it for the sink.
// Depends on qbm_pkg.
`timescale 1ns / 1ps
`default_nettype none

module qbm_final_cell (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           en,
  input  wire logic           in_vld,
  input  wire qbm_pkg::lane_t in_lane,
  output logic                out_vld,
  output qbm_pkg::word_t      out_word
);
  import qbm_pkg::*;

  logic  vld_r, vld_nxt;
  word_t res_r, res_nxt;
  word_t uv, uvu;

  // op(op(op(u,v),u),v)
  always_comb begin
    uv      = qop(in_lane.u, in_lane.v);
    uvu     = qop(uv, in_lane.u);
    res_nxt = qop(uvu, in_lane.v);
    vld_nxt = in_vld;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      res_r <= res_nxt;
    end
  end

  assign out_vld  = vld_r;
  assign out_word = res_r;

endmodule

`default_nettype wire

### rtl/core/quasigroup_block_mix.sv
// Top level of the quasigroup block mix: chain of round cells and output cell.
// Depends on qbm_pkg, qbm_round_cell, qbm_final_cell and the macros header.
`timescale 1ns / 1ps
`default_nettype none
`include "quasigroup_block_mix_macros.svh"

// Mixes two 63-bit words (21 three-bit digits each) through 20 quasigroup
// rounds and a final fold. One transaction is accepted every cycle unless
// the chain is held; each result passes through the 20 round cells in the
// chain and then the registered output cell.
// The block keeps no state between transactions. While a finished result
// waits under out_stall the whole chain holds and in_stall is raised;
// otherwise the input is never stalled.
module quasigroup_block_mix (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   in_valid,
  output logic                        in_stall,
  input  wire logic [qbm_pkg::WORD_W-1:0] in_first_operand,
  input  wire logic [qbm_pkg::WORD_W-1:0] in_second_operand,
  output logic                        out_valid,
  input  wire logic                   out_stall,
  output logic [qbm_pkg::WORD_W-1:0]  out_mixed_result
);
  import qbm_pkg::*;

  logic  en;
  logic  vld  [ROUNDS+1];
  lane_t lane [ROUNDS+1];

  // Chain advances unless the held result is blocked
  assign en       = !(out_valid && out_stall);
  assign in_stall = !en;

  // Chain entry: both chains start at their operands
  assign vld[0]    = in_valid;
  assign lane[0].a = in_first_operand;
  assign lane[0].b = in_second_operand;
  assign lane[0].u = in_first_operand;
  assign lane[0].v = in_second_operand;

  // Round cells
  for (genvar g = 0; g < ROUNDS; g++) begin : g_round
    qbm_round_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .en       (en),
      .in_vld   (vld[g]),
      .in_lane  (lane[g]),
      .out_vld  (vld[g+1]),
      .out_lane (lane[g+1])
    );
  end

  // Output cell
  qbm_final_cell u_final (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_vld   (vld[ROUNDS]),
    .in_lane  (lane[ROUNDS]),
    .out_vld  (out_valid),
    .out_word (out_mixed_result)
  );

  // Checks on the chain control
  `QBM_ASSERT_IMPL(a_stall_needs_result, in_stall, out_valid, "input stalled without a held result")
  `QBM_ASSERT_NEXT(a_accept_enters, in_valid && !in_stall, vld[1], "accepted transaction lost at entry")
  `QBM_ASSERT_NEXT(a_last_reaches_out, vld[ROUNDS] && en, out_valid, "last round result not delivered")

endmodule

`default_nettype wire

### bench/tb_quasigroup_block_mix.sv
// Testbench for quasigroup_block_mix: directed vectors, then random operand pairs.
// Each result is checked against a local quasigroup mix model or a known result.
// Depends on qbm_pkg and the quasigroup_block_mix RTL.
`timescale 1ns / 1ps

module tb_quasigroup_block_mix;
  import qbm_pkg::word_t;

  localparam int CLK_PERIOD   = 20;
  localparam int MIX_ROUNDS   = 20;
  localparam int DIGIT_COUNT  = 21;
  localparam int LATENCY      = 21;
  localparam int RANDOM_ITEMS = 1300;
  localparam int HOLD_CYCLES  = 80;
  localparam int WATCHDOG_MAX = 2000;

  // Digit value 1 in every digit position; scale it to get any uniform word
  localparam word_t DIGIT_ONES = 63'h1249249249249249;
  localparam word_t WORD_MAX   = 63'h7FFF_FFFF_FFFF_FFFF;

  // 8x8 quasigroup, row = first digit, column = second digit
  localparam logic [2:0] QUASI_TBL [8][8] = '{
    '{3'd2, 3'd0, 3'd4, 3'd3, 3'd5, 3'd7, 3'd1, 3'd6},
    '{3'd1, 3'd5, 3'd3, 3'd4, 3'd0, 3'd6, 3'd2, 3'd7},
    '{3'd7, 3'd4, 3'd0, 3'd5, 3'd3, 3'd2, 3'd6, 3'd1},
    '{3'd0, 3'd2, 3'd7, 3'd6, 3'd1, 3'd4, 3'd5, 3'd3},
    '{3'd3, 3'd6, 3'd1, 3'd2, 3'd7, 3'd5, 3'd4, 3'd0},
    '{3'd6, 3'd3, 3'd5, 3'd0, 3'd4, 3'd1, 3'd7, 3'd2},
    '{3'd4, 3'd7, 3'd2, 3'd1, 3'd6, 3'd0, 3'd3, 3'd5},
    '{3'd5, 3'd1, 3'd6, 3'd7, 3'd2, 3'd3, 3'd0, 3'd4}
  };

  typedef struct packed {
    word_t first;
    word_t second;
    bit    has_known;
    word_t known;
  } mix_vector_t;

  // Directed vectors; the known results of the uniform all-zero and
  // all-seven words follow from the seven-long digit cycles of the table
  localparam mix_vector_t DIRECTED_VECTORS [16] = '{
    '{63'h0,                  63'h0,                  1'b1, 63'h4924924924924924},
    '{WORD_MAX,               WORD_MAX,               1'b1, 63'h2492492492492492},
    '{63'h0,                  WORD_MAX,               1'b0, 63'h0},
    '{WORD_MAX,               63'h0,                  1'b0, 63'h0},
    '{63'h1,                  63'h0,                  1'b0, 63'h0},
    '{63'h0,                  63'h4000_0000_0000_0000, 1'b0, 63'h0},
    '{63'h4000_0000_0000_0000, 63'h1,                 1'b0, 63'h0},
    '{63'h5555555555555555,   63'h2AAAAAAAAAAAAAAA,   1'b0, 63'h0},
    '{63'h2AAAAAAAAAAAAAAA,   63'h5555555555555555,   1'b0, 63'h0},
    '{DIGIT_ONES * 2,         DIGIT_ONES * 5,         1'b0, 63'h0},
    '{DIGIT_ONES * 3,         DIGIT_ONES * 4,         1'b0, 63'h0},
    '{DIGIT_ONES * 6,         DIGIT_ONES,             1'b0, 63'h0},
    '{63'h0123456789ABCDEF,   63'h7EDCBA9876543210,   1'b0, 63'h0},
    '{63'h7000_0000_0000_0000, 63'h7,                 1'b0, 63'h0},
    '{63'h7,                  63'h7000_0000_0000_0000, 1'b0, 63'h0},
    '{63'h0FFF_FFFF_C000_0000, 63'h3FFF_FFFF_0000_0FFF, 1'b0, 63'h0}
  };

  logic  clk;
  logic  rst_n;
  logic  in_valid;
  logic  in_stall;
  word_t in_first_operand;
  word_t in_second_operand;
  logic  out_valid;
  logic  out_stall;
  word_t out_mixed_result;

  word_t pending_mix_q [$];
  int    mismatch_count = 0;
  int    quiet_cycles = 0;
  bit    quiet_stretch;
  bit    hold_request;

  quasigroup_block_mix u_top (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_first_operand  (in_first_operand),
    .in_second_operand (in_second_operand),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_mixed_result  (out_mixed_result)
  );

  initial begin
    clk = 1'b0;
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  // Digit-wise table lookup over all 21 digits
  function automatic word_t digit_mix(input word_t p, input word_t q);
    word_t      r;
    logic [2:0] x;
    logic [2:0] y;
    r = '0;
    for (int d = 0; d < DIGIT_COUNT; d++) begin
      x = p[3*d +: 3];
      y = q[3*d +: 3];
      r |= word_t'(QUASI_TBL[x][y]) << (3 * d);
    end
    return r;
  endfunction

  // Expected mixed block: two chains fed by rotating operands, then a fold
  function automatic word_t mix_block(input word_t first, input word_t second);
    word_t a;
    word_t b;
    word_t u;
    word_t v;
    a = first;
    b = second;
    u = first;
    v = second;
    for (int r = 0; r < MIX_ROUNDS; r++) begin
      a = (a >> 3) | (a << 60);
      b = (b >> 3) | (b << 60);
      u = digit_mix(u, a);
      v = digit_mix(v, b);
    end
    return digit_mix(digit_mix(digit_mix(u, v), u), v);
  endfunction

  // Operand mix: extremes, uniform digits, single bits, sparse, dense and plain random words
  function automatic word_t random_operand();
    word_t w;
    w = word_t'({$urandom, $urandom});
    case ($urandom_range(9))
      0: w = '0;
      1: w = WORD_MAX;
      2: w = DIGIT_ONES * $urandom_range(7);
      3: w = word_t'(1) << $urandom_range(62);
      4: w = w & word_t'({$urandom, $urandom}) & word_t'({$urandom, $urandom});
      5: w = w | word_t'({$urandom, $urandom});
      default: ;
    endcase
    return w;
  endfunction

  // Offer one transaction; called and returns at a falling edge
  task automatic offer_pair(input word_t first, input word_t second,
                            input bit has_known, input word_t known);
    while (!quiet_stretch && $urandom_range(99) < 33) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid          <= 1'b1;
    in_first_operand  <= first;
    in_second_operand <= second;
    do @(posedge clk); while (in_stall);
    pending_mix_q.push_back(has_known ? known : mix_block(first, second));
    @(negedge clk);
  endtask

  // Sender pause until every outstanding result has come back
  task automatic drain_pause();
    in_valid <= 1'b0;
    do @(negedge clk); while (pending_mix_q.size() != 0);
  endtask

  // Receiver: random stalls, a quiet stretch, and one long hold-off
  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request) begin
        out_stall <= 1'b1;
        for (int i = 1; i < HOLD_CYCLES; i++) @(negedge clk);
        hold_request = 1'b0;
      end else begin
        out_stall <= !quiet_stretch && ($urandom_range(99) < 33);
      end
    end
  end

  // Result check against the oldest expectation
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (pending_mix_q.size() == 0) begin
        $error("mixed_result: no transaction pending, got %h", out_mixed_result);
        mismatch_count++;
      end else begin
        if (out_mixed_result !== pending_mix_q[0]) begin
          $error("mixed_result: expected %h, got %h", pending_mix_q[0], out_mixed_result);
          mismatch_count++;
        end
        void'(pending_mix_q.pop_front());
      end
    end
  end

  // Watchdog on cycles with no transaction on either side
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_MAX) begin
      $display("watchdog: no transaction for %0d cycles", quiet_cycles);
      $display("CHECKS FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Main sequence: reset, directed vectors, random pairs, drain
  initial begin
    rst_n             = 1'b0;
    in_valid          = 1'b0;
    in_first_operand  = '0;
    in_second_operand = '0;
    quiet_stretch     = 1'b0;
    hold_request      = 1'b0;
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (DIRECTED_VECTORS[i]) begin
      offer_pair(DIRECTED_VECTORS[i].first, DIRECTED_VECTORS[i].second,
                 DIRECTED_VECTORS[i].has_known, DIRECTED_VECTORS[i].known);
    end
    drain_pause();

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n == 300) quiet_stretch = 1'b1;
      if (n == 550) quiet_stretch = 1'b0;
      // long receiver hold-off while the sender keeps going
      if (n == 700) hold_request = 1'b1;
      if (n == 1000) drain_pause();
      offer_pair(random_operand(), random_operand(), 1'b0, '0);
    end
    in_valid <= 1'b0;

    while (pending_mix_q.size() != 0) @(posedge clk);
    repeat (2 * LATENCY) @(posedge clk);
    if (mismatch_count == 0 && pending_mix_q.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

### sim.f
+incdir+rtl/core
rtl/core/qbm_pkg.sv
rtl/core/qbm_round_cell.sv
rtl/core/qbm_final_cell.sv
rtl/core/quasigroup_block_mix.sv
bench/tb_quasigroup_block_mix.sv
